@@ rtl/core/nearest_seed_voronoi_colorer_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the nearest seed colorer.
// Each macro samples on clk and is disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef NEAREST_SEED_VORONOI_COLORER_ASSERT_SVH
`define NEAREST_SEED_VORONOI_COLORER_ASSERT_SVH

// The condition holds at every sampled edge.
`define NSVC_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// The trigger implies the condition at the same edge.
`define NSVC_ASSERT_IMPL(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
    else $error(msg);

// The trigger implies the condition at the next edge.
`define NSVC_ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ rtl/core/nsvc_pkg.sv @@
// ---------------------------------------------------------------------------
// nsvc_pkg
// Shared constants and operation codes of the nearest seed colorer.
// ---------------------------------------------------------------------------
`default_nettype none

package nsvc_pkg;

  localparam int MAX_SEEDS_DEF  = 256;
  localparam int COORD_BITS_DEF = 12;

  localparam int POS_W   = 12;
  localparam int COLOR_W = 8;
  localparam int INDEX_W = 8;
  localparam int CFG_W   = 9;

  typedef logic [COLOR_W-1:0] color_t;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

endpackage

`default_nettype wire

@@ rtl/core/nearest_seed_voronoi_colorer.sv @@
// A pixel query searches the seeds below the effective seed count; with no
// seed searched, the result reports no seed.
// One seed is read per cycle through the single read port of the seed table.
// It then passes a distance pipeline of absolute difference, square and compare.
// The input is ready again as the result is loaded, so queries do not overlap.
// Reset clears the control state and the seed count but not the seed table.
// ---------------------------------------------------------------------------
// nearest_seed_voronoi_colorer
// Brute force nearest seed search over a seed table with squared distances.
// ---------------------------------------------------------------------------
`default_nettype none
`include "nearest_seed_voronoi_colorer_assert.svh"

module nearest_seed_voronoi_colorer
  import nsvc_pkg::*;
#(
  parameter int MAX_SEEDS  = MAX_SEEDS_DEF,
  parameter int COORD_BITS = COORD_BITS_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,

  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CFG_W-1:0]   cfg_seed_count,

  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               in_op,
  input  wire logic [INDEX_W-1:0] in_seed_index,
  input  wire logic [POS_W-1:0]   in_pos_x,
  input  wire logic [POS_W-1:0]   in_pos_y,
  input  wire color_t             in_red,
  input  wire color_t             in_green,
  input  wire color_t             in_blue,
  input  wire color_t             in_alpha,

  output logic                    out_valid,
  input  wire logic               out_ready,
  output color_t                  out_red,
  output color_t                  out_green,
  output color_t                  out_blue,
  output color_t                  out_alpha,
  output logic [INDEX_W-1:0]      out_nearest_index,
  output logic                    out_no_seed
);

  localparam int CW    = (COORD_BITS < POS_W) ? COORD_BITS : POS_W;
  localparam int IW    = (MAX_SEEDS > 1) ? $clog2(MAX_SEEDS) : 1;
  localparam int CNT_W = $clog2(MAX_SEEDS + 1);
  localparam int SQ_W  = 2 * CW;
  localparam int DW    = SQ_W + 1;
  localparam int RGBA_W = 4 * COLOR_W;
  localparam int ENT_W = 2 * CW + RGBA_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state_r, state_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [CNT_W-1:0]  scan_r, scan_nxt;
  logic [CW-1:0]     px_r, py_r;

  logic [ENT_W-1:0]  seed_mem [MAX_SEEDS];
  logic [ENT_W-1:0]  mem_q_r;
  logic [ENT_W-1:0]  wr_data;
  logic [IW-1:0]     wr_addr;
  logic              wr_en;
  logic [IW-1:0]     rd_addr;

  logic              v0_r, v1_r, v2_r;
  logic [IW-1:0]     idx0_r, idx1_r, idx2_r;
  logic [RGBA_W-1:0] rgba1_r, rgba2_r;
  logic [CW-1:0]     dx1_r, dy1_r;
  logic [SQ_W-1:0]   sqx2_r, sqy2_r;

  logic [CW-1:0]     seed_x0, seed_y0;
  logic [DW-1:0]     dist_sum;
  logic              take_best;
  logic              found_r;
  logic [DW-1:0]     best_dist_r;
  logic [IW-1:0]     best_idx_r;
  logic [RGBA_W-1:0] best_rgba_r;

  logic              in_fire, query_fire, issue, scan_end, out_free;
  logic [31:0]       cfg_ext, idx_ext, best_ext;

  logic              out_valid_r;
  color_t            out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic [INDEX_W-1:0] out_index_r;
  logic              out_no_seed_r;

  assign cfg_ready  = 1'b1;
  assign in_ready   = (state_r == ST_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign query_fire = in_fire && (in_op == OP_QUERY);
  assign out_free   = !out_valid_r || out_ready;

  assign cfg_ext = 32'(cfg_seed_count);
  assign cnt_nxt = (cfg_ext > 32'(MAX_SEEDS)) ? CNT_W'(MAX_SEEDS) : cfg_ext[CNT_W-1:0];

  assign idx_ext = 32'(in_seed_index);
  assign wr_addr = idx_ext[IW-1:0];
  assign wr_en   = in_fire && (in_op == OP_WRITE) && (idx_ext < 32'(MAX_SEEDS));
  assign wr_data = {in_alpha, in_blue, in_green, in_red,
                    in_pos_y[CW-1:0], in_pos_x[CW-1:0]};

  assign issue    = (state_r == ST_SCAN) && (scan_r < cnt_r);
  assign rd_addr  = scan_r[IW-1:0];
  assign scan_end = (state_r == ST_SCAN) && !issue && !v0_r && !v1_r && !v2_r;

  always_comb begin
    state_nxt = state_r;
    scan_nxt  = scan_r;
    case (state_r)
      ST_IDLE: begin
        if (query_fire) begin
          state_nxt = ST_SCAN;
          scan_nxt  = '0;
        end
      end
      ST_SCAN: begin
        if (issue) begin
          scan_nxt = scan_r + 1'b1;
        end
        if (scan_end) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      scan_r  <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      scan_r  <= scan_nxt;
      if (cfg_valid && cfg_ready) begin
        cnt_r <= cnt_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (query_fire) begin
      px_r <= in_pos_x[CW-1:0];
      py_r <= in_pos_y[CW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      seed_mem[wr_addr] <= wr_data;
    end
    mem_q_r <= seed_mem[rd_addr];
  end

  assign seed_x0 = mem_q_r[CW-1:0];
  assign seed_y0 = mem_q_r[2*CW-1:CW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v0_r <= issue;
      v1_r <= v0_r;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    idx0_r  <= rd_addr;
    idx1_r  <= idx0_r;
    idx2_r  <= idx1_r;
    rgba1_r <= mem_q_r[ENT_W-1:2*CW];
    rgba2_r <= rgba1_r;
    dx1_r   <= (seed_x0 >= px_r) ? (seed_x0 - px_r) : (px_r - seed_x0);
    dy1_r   <= (seed_y0 >= py_r) ? (seed_y0 - py_r) : (py_r - seed_y0);
    sqx2_r  <= SQ_W'(dx1_r) * SQ_W'(dx1_r);
    sqy2_r  <= SQ_W'(dy1_r) * SQ_W'(dy1_r);
  end

  assign dist_sum  = DW'(sqx2_r) + DW'(sqy2_r);
  assign take_best = v2_r && (!found_r || (dist_sum < best_dist_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else if (query_fire) begin
      found_r <= 1'b0;
    end else if (take_best) begin
      found_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take_best) begin
      best_dist_r <= dist_sum;
      best_idx_r  <= idx2_r;
      best_rgba_r <= rgba2_r;
    end
  end

  assign best_ext = 32'(best_idx_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DONE) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DONE) && out_free) begin
      if (found_r) begin
        out_red_r     <= best_rgba_r[COLOR_W-1:0];
        out_green_r   <= best_rgba_r[2*COLOR_W-1:COLOR_W];
        out_blue_r    <= best_rgba_r[3*COLOR_W-1:2*COLOR_W];
        out_alpha_r   <= best_rgba_r[4*COLOR_W-1:3*COLOR_W];
        out_index_r   <= best_ext[INDEX_W-1:0];
        out_no_seed_r <= 1'b0;
      end else begin
        out_red_r     <= '0;
        out_green_r   <= '0;
        out_blue_r    <= '0;
        out_alpha_r   <= '0;
        out_index_r   <= '0;
        out_no_seed_r <= 1'b1;
      end
    end
  end

  assign out_valid         = out_valid_r;
  assign out_red           = out_red_r;
  assign out_green         = out_green_r;
  assign out_blue          = out_blue_r;
  assign out_alpha         = out_alpha_r;
  assign out_nearest_index = out_index_r;
  assign out_no_seed       = out_no_seed_r;

  `NSVC_ASSERT_IMPL(a_no_seed_zero, out_valid_r && out_no_seed_r,
    (out_red_r == '0) && (out_alpha_r == '0) && (out_index_r == '0),
    "No seed result carries a nonzero field.")
  `NSVC_ASSERT_IMPL(a_scan_bound, state_r == ST_SCAN, scan_r <= cnt_r,
    "Scan counter passed the seed count.")
  `NSVC_ASSERT_IMPL(a_pipe_in_scan, v0_r || v1_r || v2_r, state_r == ST_SCAN,
    "Distance pipeline active outside a scan.")
  `NSVC_ASSERT_NEXT(a_query_starts, query_fire, state_r == ST_SCAN && scan_r == '0,
    "Accepted query did not start a scan.")

endmodule

`default_nettype wire
